// File: rtl/core/postfix_stack_evaluator_top_defines.svh
// Assertion macros used by the evaluator top module.
`ifndef POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PSEV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the following edge.
`define PSEV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/psev_pkg.sv
package psev_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DIV_W       = VALUE_W + FRAC_BITS;
  localparam int unsigned DCNT_W      = $clog2(DIV_W);

  localparam logic [7:0] SYM_ZERO   = 8'd48;
  localparam logic [7:0] SYM_PLUS   = 8'd43;
  localparam logic [7:0] SYM_MINUS  = 8'd45;
  localparam logic [7:0] SYM_TIMES  = 8'd42;
  localparam logic [7:0] SYM_DIVIDE = 8'd47;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_SAT   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ALU_LIT,
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIX,
    A_DONE
  } alu_state_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_RD_A,
    T_RD_B,
    T_LOAD,
    T_EXEC,
    T_WAIT,
    T_FIN
  } top_state_e;

  typedef struct packed {
    logic                       start;
    alu_op_e                    op;
    logic signed [VALUE_W-1:0]  a;
    logic signed [VALUE_W-1:0]  b;
    logic [7:0]                 sym;
  } alu_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [VALUE_W-1:0]  value;
    logic                       sat;
    logic                       divz;
  } alu_res_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic                       sat;
  } sat_t;

  // Clamp a wide signed value to the 32-bit range.
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'(VAL_MAX)) begin
      r.value = VAL_MAX;
      r.sat   = 1'b1;
    end else if (v < 64'(VAL_MIN)) begin
      r.value = VAL_MIN;
      r.sat   = 1'b1;
    end else begin
      r.value = $signed(v[VALUE_W-1:0]);
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/postfix_stack_evaluator_top.sv
// Postfix evaluator: one character per item, one item in flight at a time.
// An operand goes straight to the ALU; an operator first reads two operands from the stack RAM.
// * adds a multiply state; / by a nonzero divisor runs the one-bit-per-cycle divider and a fix-up state.
// The last item then waits in T_FIN until its result is loaded into the output register.
// Reset clears the stack count, the status and all handshake state at once;
// stack contents are not cleared, and an entry's value is used only after it has been written.
`include "postfix_stack_evaluator_top_defines.svh"

module postfix_stack_evaluator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] value, [34:32] status, [39:35] zero
);

  import psev_pkg::*;

  top_state_e state_q, state_d;

  logic [CNT_W-1:0]          cnt_q, cnt_d;
  status_e                   err_q, err_d;
  alu_op_e                   op_q;
  logic [7:0]                sym_q;
  logic                      last_q;
  logic signed [VALUE_W-1:0] a_q;
  logic signed [VALUE_W-1:0] b_q;
  logic signed [VALUE_W-1:0] top_q;
  logic                      m_valid_q;
  logic [VALUE_W-1:0]        out_value_q;
  logic [2:0]                out_status_q;

  alu_op_e                   op_dec;
  alu_req_t                  alu_req;
  alu_res_t                  alu_res;
  logic                      is_op;
  logic [CNT_W-1:0]          cnt_m1;
  logic [CNT_W-1:0]          cnt_m2;
  logic [CNT_W-1:0]          base;
  logic                      full;
  logic                      push_done;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;
  status_e                   err_new;
  logic                      out_load;
  logic                      accept;

  always_comb begin
    case (s_axis_tdata)
      SYM_PLUS:   op_dec = ALU_ADD;
      SYM_MINUS:  op_dec = ALU_SUB;
      SYM_TIMES:  op_dec = ALU_MUL;
      SYM_DIVIDE: op_dec = ALU_DIV;
      default:    op_dec = ALU_LIT;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign is_op  = (op_q != ALU_LIT);
  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign cnt_m2 = cnt_q - CNT_W'(2);

  // Operators pop up to two entries and always find room; operands may overflow.
  assign base      = is_op ? ((cnt_q < CNT_W'(2)) ? '0 : cnt_m2) : cnt_q;
  assign full      = !is_op && (cnt_q >= CNT_W'(STACK_DEPTH));
  assign push_done = (state_q == T_WAIT) && alu_res.done;
  assign out_load  = (state_q == T_FIN) && (!m_valid_q || m_axis_tready);

  // Keep the first error of the expression, in evaluation order.
  always_comb begin
    if (is_op && (cnt_q < CNT_W'(2))) begin
      err_new = ST_UNDER;
    end else if (alu_res.divz) begin
      err_new = ST_DIVZ;
    end else if (alu_res.sat) begin
      err_new = ST_SAT;
    end else if (full) begin
      err_new = ST_OVER;
    end else begin
      err_new = ST_OK;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    err_d = err_q;
    if (push_done) begin
      if (!full) begin
        cnt_d = base + CNT_W'(1);
      end
      if (err_q == ST_OK) begin
        err_d = err_new;
      end
    end else if (out_load) begin
      cnt_d = '0;
      err_d = ST_OK;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          state_d = (op_dec == ALU_LIT) ? T_EXEC : T_RD_A;
        end
      end
      T_RD_A: state_d = T_RD_B;
      T_RD_B: state_d = T_LOAD;
      T_LOAD: state_d = T_EXEC;
      T_EXEC: state_d = T_WAIT;
      T_WAIT: begin
        if (alu_res.done) begin
          state_d = last_q ? T_FIN : T_IDLE;
        end
      end
      T_FIN: begin
        if (out_load) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == T_IDLE);
    ram_we        = push_done && !full;
    ram_raddr     = (state_q == T_RD_B) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
    alu_req.start = (state_q == T_EXEC);
    alu_req.op    = op_q;
    alu_req.a     = a_q;
    alu_req.b     = b_q;
    alu_req.sym   = sym_q;
  end

  psev_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (base[ADDR_W-1:0]),
    .wdata_i (alu_res.value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  psev_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .res_o  (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      cnt_q     <= '0;
      err_q     <= ST_OK;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_dec;
      sym_q  <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    // Missing operands read as zero.
    if (state_q == T_RD_B) begin
      a_q <= (cnt_q >= CNT_W'(1)) ? $signed(ram_rdata) : '0;
    end
    if (state_q == T_LOAD) begin
      b_q <= (cnt_q >= CNT_W'(2)) ? $signed(ram_rdata) : '0;
    end
    // The last value written is always the top of stack.
    if (ram_we) begin
      top_q <= alu_res.value;
    end
    if (out_load) begin
      out_value_q  <= (cnt_q == '0) ? '0 : top_q;
      out_status_q <= ((cnt_q == '0) && (err_q == ST_OK)) ? ST_UNDER : err_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, out_status_q, out_value_q};

  `PSEV_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `PSEV_ASSERT(a_done_in_wait, !alu_res.done || (state_q == T_WAIT), "ALU result outside wait")
  `PSEV_ASSERT_NEXT(a_clear_after_out, out_load, (cnt_q == '0) && (err_q == ST_OK), "not cleared")
  `PSEV_ASSERT(a_out_from_fin, !$rose(m_valid_q) || $past(state_q == T_FIN), "stray result")

endmodule

// File: rtl/core/psev_ram.sv
module psev_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/psev_alu.sv
module psev_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psev_pkg::alu_req_t req_i,
  output psev_pkg::alu_res_t res_o
);

  import psev_pkg::*;

  alu_state_e state_q, state_d;

  logic signed [63:0]         prod_q;
  logic [DIV_W-1:0]           quo_q;
  logic [VALUE_W-1:0]         rem_q;
  logic [VALUE_W-1:0]         div_q;
  logic                       neg_q;
  logic [DCNT_W-1:0]          dcnt_q;
  logic signed [VALUE_W-1:0]  res_value_q;
  logic                       res_sat_q;
  logic                       res_divz_q;

  logic [VALUE_W-1:0]         a_mag;
  logic [VALUE_W-1:0]         b_mag;
  logic [VALUE_W:0]           rem_sh;
  logic [VALUE_W:0]           rem_diff;
  logic                       q_bit;
  logic [VALUE_W-1:0]         rem_next;
  logic signed [63:0]         mag64;
  logic signed [63:0]         lit64;
  logic signed [63:0]         wide;
  sat_t                       sat_res;
  logic                       div_last;

  assign a_mag = req_i.a[VALUE_W-1] ? (~req_i.a + VALUE_W'(1)) : req_i.a;
  assign b_mag = req_i.b[VALUE_W-1] ? (~req_i.b + VALUE_W'(1)) : req_i.b;

  // One restoring division step per cycle.
  assign rem_sh   = {rem_q, quo_q[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_q};
  assign q_bit    = (rem_sh >= {1'b0, div_q});
  assign rem_next = q_bit ? rem_diff[VALUE_W-1:0] : rem_sh[VALUE_W-1:0];
  assign div_last = (dcnt_q == DCNT_W'(DIV_W - 1));

  assign mag64 = $signed(64'(quo_q));
  assign lit64 = 64'($signed({1'b0, req_i.sym}) - $signed({1'b0, SYM_ZERO})) <<< FRAC_BITS;

  always_comb begin
    case (state_q)
      A_MUL:   wide = prod_q >>> FRAC_BITS;
      A_FIX:   wide = neg_q ? -mag64 : mag64;
      default: begin
        case (req_i.op)
          ALU_ADD: wide = 64'(req_i.b) + 64'(req_i.a);
          ALU_SUB: wide = 64'(req_i.b) - 64'(req_i.a);
          default: wide = lit64;
        endcase
      end
    endcase
    sat_res = sat32(wide);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            ALU_MUL: state_d = A_MUL;
            ALU_DIV: state_d = (req_i.a == '0) ? A_DONE : A_DIV;
            default: state_d = A_DONE;
          endcase
        end
      end
      A_MUL:   state_d = A_DONE;
      A_DIV:   state_d = div_last ? A_FIX : A_DIV;
      A_FIX:   state_d = A_DONE;
      A_DONE:  state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_comb begin
    res_o.done  = (state_q == A_DONE);
    res_o.value = res_value_q;
    res_o.sat   = res_sat_q;
    res_o.divz  = res_divz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            ALU_MUL: prod_q <= req_i.b * req_i.a;
            ALU_DIV: begin
              if (req_i.a == '0) begin
                res_value_q <= req_i.b[VALUE_W-1] ? VAL_MIN : VAL_MAX;
                res_sat_q   <= 1'b0;
                res_divz_q  <= 1'b1;
              end else begin
                quo_q  <= DIV_W'(b_mag) << FRAC_BITS;
                rem_q  <= '0;
                div_q  <= a_mag;
                neg_q  <= req_i.a[VALUE_W-1] ^ req_i.b[VALUE_W-1];
                dcnt_q <= '0;
              end
            end
            default: begin
              res_value_q <= sat_res.value;
              res_sat_q   <= sat_res.sat;
              res_divz_q  <= 1'b0;
            end
          endcase
        end
      end
      A_DIV: begin
        rem_q  <= rem_next;
        quo_q  <= {quo_q[DIV_W-2:0], q_bit};
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      A_MUL, A_FIX: begin
        res_value_q <= sat_res.value;
        res_sat_q   <= sat_res.sat;
        res_divz_q  <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import psev_pkg::*;

  localparam int unsigned DEPTH           = STACK_DEPTH;
  localparam int unsigned FRAC            = FRAC_BITS;
  localparam longint      FIX_ONE         = longint'(1) << FRAC;
  localparam int unsigned ITEMS_PER_PHASE = 220;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned N_ROWS          = 14;

  typedef struct {
    logic signed [31:0] value;
    status_e            status;
  } eval_result_t;

  typedef struct {
    logic [7:0]         sym;
    logic               last;
    int unsigned        reps;
    logic               typed;
    logic signed [31:0] value;
    status_e            status;
  } stim_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] symbol
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [31:0] value, [34:32] status, [39:35] zero

  postfix_stack_evaluator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Evaluator shadow state.
  logic signed [31:0] opnd_stack [DEPTH];
  int unsigned        opnd_count    = 0;
  status_e            sticky_status = ST_OK;

  eval_result_t pending_results [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_armed     = 1'b0;
  int unsigned hold_cnt       = 0;
  int unsigned items_sent     = 0;
  int unsigned exprs_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned stuck_cycles   = 0;

  // Directed items; typed expectations are read straight off the arithmetic.
  stim_row_t directed_rows [N_ROWS] = '{
    // lone divide on empty stack: underflow wins over divide by zero
    '{SYM_DIVIDE, 1'b1, 1, 1'b1, VAL_MAX, ST_UNDER},
    // add with a single operand
    '{SYM_ZERO + 8'd7, 1'b0, 1, 1'b0, '0, ST_OK},
    '{SYM_PLUS, 1'b1, 1, 1'b1, 32'sh0007_0000, ST_UNDER},
    // symbol extremes: 207.0 - (-48.0)
    '{8'd255, 1'b0, 1, 1'b0, '0, ST_OK},
    '{8'd0, 1'b0, 1, 1'b0, '0, ST_OK},
    '{SYM_MINUS, 1'b1, 1, 1'b1, 32'sh00FF_0000, ST_OK},
    // 5 / 0
    '{SYM_ZERO + 8'd5, 1'b0, 1, 1'b0, '0, ST_OK},
    '{SYM_ZERO, 1'b0, 1, 1'b0, '0, ST_OK},
    '{SYM_DIVIDE, 1'b1, 1, 1'b1, VAL_MAX, ST_DIVZ},
    // 207 * 207 saturates
    '{8'd255, 1'b0, 1, 1'b0, '0, ST_OK},
    '{8'd255, 1'b0, 1, 1'b0, '0, ST_OK},
    '{SYM_TIMES, 1'b1, 1, 1'b1, VAL_MAX, ST_SAT},
    // fill the stack, then drop one more push
    '{SYM_ZERO + 8'd9, 1'b0, DEPTH, 1'b0, '0, ST_OK},
    '{8'd0, 1'b1, 1, 1'b1, 32'sh0009_0000, ST_OVER}
  };

  function automatic void raise_status(input status_e code);
    if (sticky_status == ST_OK) sticky_status = code;
  endfunction

  function automatic longint pop_operand();
    if (opnd_count == 0) begin
      raise_status(ST_UNDER);
      return 0;
    end
    opnd_count--;
    return longint'(opnd_stack[opnd_count]);
  endfunction

  function automatic void push_operand(input longint v);
    logic signed [31:0] clamped;
    if (v > longint'(VAL_MAX)) begin
      raise_status(ST_SAT);
      clamped = VAL_MAX;
    end else if (v < longint'(VAL_MIN)) begin
      raise_status(ST_SAT);
      clamped = VAL_MIN;
    end else begin
      clamped = 32'(v);
    end
    if (opnd_count >= DEPTH) begin
      raise_status(ST_OVER);
    end else begin
      opnd_stack[opnd_count] = clamped;
      opnd_count++;
    end
  endfunction

  function automatic logic eval_symbol(input logic [7:0] sym, input logic last,
                                       output eval_result_t res);
    longint a;
    longint b;
    longint r;
    res.value  = '0;
    res.status = ST_OK;
    if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_TIMES || sym == SYM_DIVIDE) begin
      a = pop_operand();
      b = pop_operand();
      if (sym == SYM_PLUS) begin
        r = b + a;
      end else if (sym == SYM_MINUS) begin
        r = b - a;
      end else if (sym == SYM_TIMES) begin
        r = (b * a) >>> FRAC;   // arithmetic shift floors
      end else if (a == 0) begin
        raise_status(ST_DIVZ);
        r = (b >= 0) ? longint'(VAL_MAX) : longint'(VAL_MIN);
      end else begin
        r = (b * FIX_ONE) / a;
      end
      push_operand(r);
    end else begin
      push_operand((longint'(sym) - longint'(SYM_ZERO)) * FIX_ONE);
    end
    if (!last) return 1'b0;
    if (opnd_count == 0) raise_status(ST_UNDER);
    else res.value = opnd_stack[opnd_count - 1];
    res.status    = sticky_status;
    opnd_count    = 0;
    sticky_status = ST_OK;
    return 1'b1;
  endfunction

  // Offer one item, predict on acceptance; a typed expectation replaces the prediction.
  task automatic offer_symbol(input logic [7:0] sym, input logic last,
                              input logic typed, input eval_result_t typed_res);
    eval_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (eval_symbol(sym, last, predicted))
      pending_results.push_back(typed ? typed_res : predicted);
  endtask

  function automatic logic [7:0] random_operand();
    if ($urandom_range(99) < 80) return SYM_ZERO + 8'($urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(3))
      0:       return SYM_PLUS;
      1:       return SYM_MINUS;
      2:       return SYM_TIMES;
      default: return SYM_DIVIDE;
    endcase
  endfunction

  task automatic send_expression();
    logic [7:0]   syms [$];
    eval_result_t unused;
    int unsigned  pick;
    int unsigned  n;
    int unsigned  depth_now;
    unused.value  = '0;
    unused.status = ST_OK;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // well-formed: reduce at random while operands arrive
      n = $urandom_range(1, 6);
      syms.push_back(random_operand());
      depth_now = 1;
      for (int unsigned i = 1; i < n; i++) begin
        syms.push_back(random_operand());
        depth_now++;
        while (depth_now > 1 && $urandom_range(1) == 1) begin
          syms.push_back(random_operator());
          depth_now--;
        end
      end
      while (depth_now > 1) begin
        syms.push_back(random_operator());
        depth_now--;
      end
    end else if (pick < 82) begin
      n = $urandom_range(1, 8);
      repeat (n) syms.push_back(($urandom_range(2) == 0) ? random_operator()
                                                          : 8'($urandom_range(255)));
    end else if (pick < 92) begin
      // starve the operators
      n = $urandom_range(0, 2);
      repeat (n) syms.push_back(random_operand());
      repeat ($urandom_range(n + 1, n + 3)) syms.push_back(random_operator());
    end else begin
      n = $urandom_range(DEPTH - 2, DEPTH + 4);
      repeat (n) syms.push_back(random_operand());
      repeat ($urandom_range(0, 3)) syms.push_back(random_operator());
    end
    foreach (syms[i]) offer_symbol(syms[i], i == syms.size() - 1, 1'b0, unused);
    exprs_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: random stalls plus one long hold-off once armed.
  always @(posedge clk_i) begin
    if (hold_armed && hold_cnt < LONG_HOLD) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    eval_result_t want;
    logic signed [31:0] got_value;
    logic [2:0]         got_status;
    got_value  = $signed(m_axis_tdata[31:0]);
    got_status = m_axis_tdata[34:32];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: value %h status %0d", got_value, got_status);
      end else begin
        want = pending_results.pop_front();
        if (got_value !== want.value || got_status !== want.status) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     want.value, want.status, got_value, got_status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    eval_result_t row_res;
    int unsigned  phase_start;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      row_res.value  = directed_rows[r].value;
      row_res.status = directed_rows[r].status;
      repeat (directed_rows[r].reps)
        offer_symbol(directed_rows[r].sym, directed_rows[r].last,
                     directed_rows[r].typed, row_res);
    end
    drain_results();

    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        send_expression();
        // hold the receiver off while the sender keeps pushing
        if (phase == 0 && items_sent - phase_start > 60) hold_armed <= 1'b1;
      end
      drain_results();
    end

    if (pending_results.size() != 0) mismatches += pending_results.size();
    $display("run covered %0d items in %0d expressions, %0d results checked, %0d mismatches",
             items_sent, exprs_sent, results_seen, mismatches);
    $display("phases: no idling, sender idle, receiver stall, both; one long receiver hold-off");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: postfix_stack_evaluator_top.f
+incdir+rtl/core
rtl/core/psev_pkg.sv
rtl/core/psev_ram.sv
rtl/core/psev_alu.sv
rtl/core/postfix_stack_evaluator_top.sv
verif/tb_top.sv
